@@ hw/rtl/csrmb_pkg.sv @@
// Shared types and constants of the CSR matrix build and lookup block.
`timescale 1ns / 1ps
`default_nettype none

package csrmb_pkg;

	localparam int ACTION_W  = 2;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int VALUE_W   = 64;
	localparam int SLOT_W    = 12;
	localparam int COUNT_W   = 13;
	localparam int CFG_W     = 11;
	localparam int IN_DATA_W = 112;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT   = 2'd0,
		ACT_FINALIZE = 2'd1,
		ACT_LOOKUP   = 2'd2,
		ACT_CLEAR    = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_INS_RD,
		ST_INS_WR,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_LK_RD0,
		ST_LK_RD1,
		ST_LK_END,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_CLR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic ins_rd;
		logic ins_wr;
		logic fin_init;
		logic fin_rd;
		logic fin_wr;
		logic lk_rd0;
		logic lk_rd1;
		logic lk_end;
		logic scan_rd;
		logic scan_next;
		logic hit;
		logic clr_init;
		logic clr_step;
		logic set_err;
		logic push;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic ins_bad;
		logic fin_bad;
		logic lk_bad;
		logic fin_last;
		logic clr_last;
		logic scan_empty;
		logic col_match;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/csr_matrix_build_and_lookup.sv @@
// Top level of the compressed sparse row matrix build and lookup block.
//
// One result transaction per input transaction, one item in flight at a time. Insert is a
// read-modify-write of the row count in the offset memory; finalize does one offset memory
// read and one write per row for the running sum; lookup does two offset reads, then one
// slot memory read and one column compare per slot scanned, ending early on a hit; clear
// zeroes one offset entry per cycle. Errors go straight to the result. A finished item
// waits while the output register stays full. After reset a clearing pass zeroes the
// offset memory while s_tready stays low; configuration writes are taken throughout. A new
// item is accepted while a finished result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module csr_matrix_build_and_lookup #(
	parameter int MAX_ROWS    = 1024,
	parameter int MAX_ENTRIES = 4096,
	parameter int VALUE_BITS  = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// row_index[9:0], col_index[19:10], entry_value[83:20], slot_index[95:84],
	// entry_count[108:96], zero fill
	input  wire logic [csrmb_pkg::IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  wire logic [csrmb_pkg::ACTION_W-1:0]   s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// read_value[63:0]
	output logic      [csrmb_pkg::VALUE_W-1:0]    m_tdata,
	// found[0], status[1]
	output logic      [1:0]                       m_tuser,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [csrmb_pkg::CFG_W-1:0]      cfg_data
);

	import csrmb_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	csrmb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.stat    (stat),
		.in_ready(s_tready),
		.cmd     (cmd)
	);

	csrmb_dp #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_ENTRIES(MAX_ENTRIES),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (s_tdata),
		.in_user  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);

endmodule

`default_nettype wire

@@ hw/rtl/csrmb_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module csrmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/csrmb_ctrl.sv @@
// Controller state machine of the CSR matrix block.
`timescale 1ns / 1ps
`default_nettype none

module csrmb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire csrmb_pkg::stat_t stat,
	output logic                in_ready,
	output csrmb_pkg::cmd_t     cmd
);

	import csrmb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (stat.action)
					ACT_INSERT:   state_d = stat.ins_bad ? ST_DONE : ST_INS_RD;
					ACT_FINALIZE: state_d = stat.fin_bad ? ST_DONE : ST_FIN_RD;
					ACT_LOOKUP:   state_d = stat.lk_bad ? ST_DONE : ST_LK_RD0;
					ACT_CLEAR:    state_d = ST_CLR;
				endcase
			end
			ST_INS_RD:   state_d = ST_INS_WR;
			ST_INS_WR:   state_d = ST_DONE;
			ST_FIN_RD:   state_d = ST_FIN_WR;
			ST_FIN_WR:   state_d = stat.fin_last ? ST_DONE : ST_FIN_RD;
			ST_LK_RD0:   state_d = ST_LK_RD1;
			ST_LK_RD1:   state_d = ST_LK_END;
			ST_LK_END:   state_d = ST_SCAN_RD;
			ST_SCAN_RD:  state_d = stat.scan_empty ? ST_DONE : ST_SCAN_CMP;
			ST_SCAN_CMP: state_d = stat.col_match ? ST_DONE : ST_SCAN_RD;
			ST_CLR: begin
				if (stat.clr_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT:   cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_DECODE: begin
				unique case (stat.action)
					ACT_INSERT:   cmd.set_err = stat.ins_bad;
					ACT_FINALIZE: begin
						cmd.set_err  = stat.fin_bad;
						cmd.fin_init = !stat.fin_bad;
					end
					ACT_LOOKUP:   cmd.set_err = stat.lk_bad;
					ACT_CLEAR:    cmd.clr_init = 1'b1;
				endcase
			end
			ST_INS_RD: cmd.ins_rd = 1'b1;
			ST_INS_WR: cmd.ins_wr = 1'b1;
			ST_FIN_RD: cmd.fin_rd = 1'b1;
			ST_FIN_WR: cmd.fin_wr = 1'b1;
			ST_LK_RD0: cmd.lk_rd0 = 1'b1;
			ST_LK_RD1: cmd.lk_rd1 = 1'b1;
			ST_LK_END: cmd.lk_end = 1'b1;
			ST_SCAN_RD: cmd.scan_rd = !stat.scan_empty;
			ST_SCAN_CMP: begin
				cmd.hit       = stat.col_match;
				cmd.scan_next = !stat.col_match;
			end
			ST_CLR:    cmd.clr_step = 1'b1;
			ST_DONE:   cmd.push = stat.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/csrmb_dp.sv @@
// Datapath of the CSR matrix block: item registers, offset and slot stores, result register.
`timescale 1ns / 1ps
`default_nettype none

module csrmb_dp #(
	parameter int MAX_ROWS    = 1024,
	parameter int MAX_ENTRIES = 4096,
	parameter int VALUE_BITS  = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire csrmb_pkg::cmd_t                     cmd,
	output csrmb_pkg::stat_t                         stat,
	input  wire logic [csrmb_pkg::IN_DATA_W-1:0]     in_data,
	input  wire logic [csrmb_pkg::ACTION_W-1:0]      in_user,
	input  wire logic                                cfg_valid,
	input  wire logic [csrmb_pkg::CFG_W-1:0]         cfg_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [csrmb_pkg::VALUE_W-1:0]       out_data,
	output logic      [1:0]                          out_user
);

	import csrmb_pkg::*;

	localparam int RA_W   = $clog2(MAX_ROWS + 1);
	localparam int OFF_W  = $clog2(MAX_ENTRIES + 1);
	localparam int OFF_W1 = OFF_W + 1;
	localparam int SA_W   = $clog2(MAX_ENTRIES);
	localparam int CW0    = (OFF_W > RA_W) ? OFF_W : RA_W;
	localparam int CW     = (CW0 > COUNT_W) ? CW0 : COUNT_W;
	localparam int SW     = COL_W + VALUE_BITS;

	localparam logic [OFF_W1-1:0] MAX_E_X = OFF_W1'(MAX_ENTRIES);
	localparam logic [OFF_W-1:0]  MAX_E   = OFF_W'(MAX_ENTRIES);
	localparam logic [RA_W-1:0]   LAST_RA = RA_W'(MAX_ROWS);

	act_t                  action_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [COUNT_W-1:0]    count_q;
	logic [RA_W-1:0]       row_count_q;
	logic [OFF_W-1:0]      entry_total_q;
	logic [RA_W-1:0]       row_idx_q;
	logic [OFF_W-1:0]      slot_idx_q;
	logic [OFF_W-1:0]      prev_q;
	logic [OFF_W-1:0]      end_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic                  res_found_q;
	logic                  res_status_q;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_data_q;
	logic [1:0]            out_user_q;

	logic                  off_we;
	logic [RA_W-1:0]       off_waddr;
	logic [OFF_W-1:0]      off_wdata;
	logic                  off_re;
	logic [RA_W-1:0]       off_raddr;
	logic [OFF_W-1:0]      off_rd;
	logic [SW-1:0]         slot_rd;
	logic [RA_W-1:0]       row_ra;
	logic [RA_W-1:0]       row_next_ra;
	logic [OFF_W-1:0]      fin_sum;
	logic [CFG_W-1:0]      cfg_clamped;

	function automatic logic [OFF_W-1:0] sat_add(input logic [OFF_W-1:0] a,
		input logic [OFF_W-1:0] b);
		logic [OFF_W1-1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > MAX_E_X) begin
			return MAX_E;
		end
		return s[OFF_W-1:0];
	endfunction

	assign row_ra      = RA_W'(row_q);
	assign row_next_ra = row_ra + RA_W'(1);
	assign fin_sum     = sat_add(off_rd, prev_q);

	always_comb begin
		off_we    = 1'b0;
		off_waddr = row_idx_q;
		off_wdata = '0;
		priority if (cmd.ins_wr) begin
			off_we    = 1'b1;
			off_waddr = row_next_ra;
			off_wdata = sat_add(off_rd, OFF_W'(1));
		end else if (cmd.fin_init) begin
			off_we    = 1'b1;
			off_waddr = '0;
		end else if (cmd.fin_wr) begin
			off_we    = 1'b1;
			off_wdata = fin_sum;
		end else if (cmd.clr_step) begin
			off_we    = 1'b1;
		end
	end

	assign off_re = cmd.ins_rd | cmd.fin_rd | cmd.lk_rd0 | cmd.lk_rd1;

	always_comb begin
		priority if (cmd.ins_rd || cmd.lk_rd1) begin
			off_raddr = row_next_ra;
		end else if (cmd.lk_rd0) begin
			off_raddr = row_ra;
		end else begin
			off_raddr = row_idx_q;
		end
	end

	csrmb_ram #(
		.WIDTH(OFF_W),
		.DEPTH(MAX_ROWS + 1)
	) u_offsets (
		.clk  (clk),
		.we   (off_we),
		.waddr(off_waddr),
		.wdata(off_wdata),
		.re   (off_re),
		.raddr(off_raddr),
		.rdata(off_rd)
	);

	csrmb_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_ENTRIES)
	) u_slots (
		.clk  (clk),
		.we   (cmd.ins_wr),
		.waddr(SA_W'(slot_q)),
		.wdata({val_q, col_q}),
		.re   (cmd.scan_rd),
		.raddr(slot_idx_q[SA_W-1:0]),
		.rdata(slot_rd)
	);

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = CFG_W'(1);
		end else if (CW'(cfg_data) > CW'(MAX_ROWS)) begin
			cfg_clamped = CFG_W'(MAX_ROWS);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= RA_W'(MAX_ROWS);
			entry_total_q <= '0;
			row_idx_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				row_count_q <= RA_W'(cfg_clamped);
			end
			if (cmd.fin_init) begin
				entry_total_q <= OFF_W'(count_q);
			end
			priority if (cmd.clr_init) begin
				row_idx_q <= '0;
			end else if (cmd.fin_init) begin
				row_idx_q <= RA_W'(1);
			end else if (cmd.fin_wr || cmd.clr_step) begin
				row_idx_q <= row_idx_q + RA_W'(1);
			end
			out_valid_q <= cmd.push | (out_valid_q & !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q     <= act_t'(in_user);
			row_q        <= in_data[9:0];
			col_q        <= in_data[19:10];
			val_q        <= in_data[20 +: VALUE_BITS];
			slot_q       <= in_data[95:84];
			count_q      <= in_data[108:96];
			res_value_q  <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= 1'b0;
		end
		if (cmd.set_err) begin
			res_status_q <= 1'b1;
		end
		if (cmd.hit) begin
			res_value_q <= slot_rd[SW-1:COL_W];
			res_found_q <= 1'b1;
		end
		if (cmd.fin_init) begin
			prev_q <= '0;
		end else if (cmd.fin_wr) begin
			prev_q <= fin_sum;
		end
		if (cmd.lk_rd1) begin
			slot_idx_q <= off_rd;
		end else if (cmd.scan_next) begin
			slot_idx_q <= slot_idx_q + OFF_W'(1);
		end
		if (cmd.lk_end) begin
			end_q <= (off_rd > entry_total_q) ? entry_total_q : off_rd;
		end
		if (cmd.push) begin
			out_data_q <= VALUE_W'(res_value_q);
			out_user_q <= {res_status_q, res_found_q};
		end
	end

	assign stat.action     = action_q;
	assign stat.ins_bad    = (CW'(row_q) >= CW'(row_count_q)) ||
	                         (CW'(slot_q) >= CW'(MAX_ENTRIES));
	assign stat.fin_bad    = CW'(count_q) > CW'(MAX_ENTRIES);
	assign stat.lk_bad     = CW'(row_q) >= CW'(row_count_q);
	assign stat.fin_last   = row_idx_q == row_count_q;
	assign stat.clr_last   = row_idx_q == LAST_RA;
	assign stat.scan_empty = slot_idx_q >= end_q;
	assign stat.col_match  = slot_rd[COL_W-1:0] == col_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

`default_nettype wire

@@ sim/csr_matrix_build_and_lookup_tb.sv @@
// Self-checking testbench for the CSR matrix build and lookup block.
`timescale 1ns / 1ps

module csr_matrix_build_and_lookup_tb;
	import csrmb_pkg::*;

	localparam int ROWS_MAX    = 1024;
	localparam int SLOTS_MAX   = 4096;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               found;
		logic               status;
	} answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [ACTION_W-1:0]  s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [VALUE_W-1:0]   m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;

	// Mirror of the block state
	int                 rows_cfg;
	int                 offs [0:ROWS_MAX];
	logic [COL_W-1:0]   col_mem [0:SLOTS_MAX-1];
	logic [VALUE_W-1:0] val_mem [0:SLOTS_MAX-1];
	bit                 written [0:SLOTS_MAX-1];
	int                 entry_sum;

	answer_t answers_due [$];
	answer_t due_ans;
	int      failures;
	int      quiet_cycles;
	int      src_idle_pct;
	int      snk_stall_pct;
	int      hold_len;

	csr_matrix_build_and_lookup #(
		.MAX_ROWS    (ROWS_MAX),
		.MAX_ENTRIES (SLOTS_MAX),
		.VALUE_BITS  (VALUE_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int sat_slots(input int x);
		return (x > SLOTS_MAX) ? SLOTS_MAX : x;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// Expected answer for one transaction; updates the mirrored state
	function automatic answer_t csr_apply(input act_t act, input int row, input int col,
			input logic [VALUE_W-1:0] val, input int slot, input int count);
		answer_t a;
		int      lo;
		int      hi;
		a = '0;
		case (act)
			ACT_INSERT: begin
				if (row >= rows_cfg || slot >= SLOTS_MAX) begin
					a.status = 1'b1;
				end else begin
					offs[row + 1] = sat_slots(offs[row + 1] + 1);
					col_mem[slot] = col[COL_W-1:0];
					val_mem[slot] = val;
					written[slot] = 1'b1;
				end
			end
			ACT_FINALIZE: begin
				if (count > SLOTS_MAX) begin
					a.status = 1'b1;
				end else begin
					entry_sum = count;
					offs[0] = 0;
					for (int i = 1; i <= rows_cfg; i++)
						offs[i] = sat_slots(offs[i] + offs[i - 1]);
				end
			end
			ACT_LOOKUP: begin
				if (row >= rows_cfg) begin
					a.status = 1'b1;
				end else begin
					lo = offs[row];
					hi = (offs[row + 1] > entry_sum) ? entry_sum : offs[row + 1];
					for (int i = lo; i < hi; i++) begin
						if (col_mem[i] == col[COL_W-1:0]) begin
							a.value = val_mem[i];
							a.found = 1'b1;
							break;
						end
					end
				end
			end
			default: begin
				for (int i = 0; i <= ROWS_MAX; i++)
					offs[i] = 0;
			end
		endcase
		return a;
	endfunction

	// True when a lookup would read a slot that was never written
	function automatic bit scan_hits_unwritten(input int row, input int col);
		int lo;
		int hi;
		if (row >= rows_cfg)
			return 1'b0;
		lo = offs[row];
		hi = (offs[row + 1] > entry_sum) ? entry_sum : offs[row + 1];
		for (int i = lo; i < hi; i++) begin
			if (!written[i])
				return 1'b1;
			if (col_mem[i] == col[COL_W-1:0])
				return 1'b0;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input act_t act_in, input int row_in, input int col_in,
			input logic [VALUE_W-1:0] val_in, input int slot_in, input int count_in);
		act_t    act;
		int      row;
		int      col;
		answer_t ans;
		act = act_in;
		row = row_in;
		col = col_in;
		if (act == ACT_LOOKUP && scan_hits_unwritten(row, col)) begin
			if (written[offs[row]])
				col = col_mem[offs[row]];
			else if (rows_cfg < ROWS_MAX)
				row = $urandom_range(rows_cfg, ROWS_MAX - 1);
			else
				act = ACT_CLEAR;
		end
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tdata  = {3'b000, 13'(count_in), 12'(slot_in), val_in, 10'(col), 10'(row)};
		s_tuser  = act;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		ans = csr_apply(act, row, col, val_in, slot_in, count_in);
		answers_due.push_back(ans);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_rows(input int raw);
		wait_idle();
		cfg_data  = CFG_W'(raw);
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		rows_cfg = (cfg_data == 0) ? 1 : ((cfg_data > ROWS_MAX) ? ROWS_MAX : int'(cfg_data));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int pick_rows();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 32);
		if (r < 80)
			return $urandom_range(33, ROWS_MAX - 1);
		if (r < 88)
			return ROWS_MAX;
		if (r < 92)
			return 0;
		if (r < 96)
			return 2047;
		return $urandom_range(0, 2047);
	endfunction

	function automatic int pick_count();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(SLOTS_MAX + 1, 8191);
		return $urandom_range(0, SLOTS_MAX);
	endfunction

	task automatic test_after_reset();
		send_item(ACT_LOOKUP, 0, 0, rnd64(), $urandom_range(0, 4095), $urandom_range(0, 8191));
		send_item(ACT_FINALIZE, $urandom_range(0, 1023), $urandom_range(0, 1023), rnd64(),
			$urandom_range(0, 4095), 0);
		send_item(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023), rnd64(),
			$urandom_range(0, 4095), $urandom_range(0, 8191));
	endtask

	task automatic test_edges();
		set_rows(0);
		send_item(ACT_INSERT, 1, 5, rnd64(), 7, 0);
		send_item(ACT_INSERT, 0, 1023, '1, 0, 8191);
		send_item(ACT_LOOKUP, 0, 1023, '0, 4095, 0);
		send_item(ACT_FINALIZE, 0, 0, '0, 0, 8191);
		send_item(ACT_FINALIZE, 1023, 1023, '1, 4095, SLOTS_MAX + 1);
		send_item(ACT_FINALIZE, 0, 0, '0, 0, 1);
		send_item(ACT_LOOKUP, 0, 1023, '0, 0, 0);
		send_item(ACT_LOOKUP, 0, 0, '0, 0, 0);
		send_item(ACT_LOOKUP, 1023, 0, '0, 0, 0);
		set_rows(2047);
		send_item(ACT_INSERT, 1023, 0, '0, 1, 0);
		send_item(ACT_INSERT, 1023, 512, 64'h8000_0000_0000_0000, 2, 0);
		send_item(ACT_INSERT, 1023, 3, rnd64(), 4095, 0);
		send_item(ACT_FINALIZE, 0, 0, '0, 0, SLOTS_MAX);
		send_item(ACT_LOOKUP, 1023, 512, '0, 0, 0);
		send_item(ACT_LOOKUP, 1023, 0, '0, 0, 0);
		// repeat the running sum until the offsets saturate
		send_item(ACT_FINALIZE, 0, 0, '0, 0, SLOTS_MAX);
		send_item(ACT_FINALIZE, 0, 0, '0, 0, SLOTS_MAX);
		send_item(ACT_LOOKUP, 600, $urandom_range(0, 1023), '0, 0, 0);
		send_item(ACT_CLEAR, 0, 0, '0, 0, 0);
		send_item(ACT_LOOKUP, 1023, 512, '0, 0, 0);
		send_item(ACT_INSERT, 0, 0, '0, 0, 0);
		set_rows(1);
		send_item(ACT_FINALIZE, 0, 0, '0, 0, 1);
		send_item(ACT_LOOKUP, 0, 0, '0, 0, 0);
		set_rows(ROWS_MAX);
	endtask

	// Clear, inserts in row order into slots 0..n-1, finalize, then lookups
	task automatic build_and_probe(input int n_entries, input int n_lookups);
		int rows_q [$];
		int cols_q [$];
		int k;
		int r;
		int cnt;
		send_item(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023), rnd64(),
			$urandom_range(0, 4095), $urandom_range(0, 8191));
		for (int i = 0; i < n_entries; i++)
			rows_q.push_back($urandom_range(0, rows_cfg - 1));
		rows_q.sort();
		for (int i = 0; i < n_entries; i++) begin
			cols_q.push_back(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) :
				$urandom_range(0, 1023));
			send_item(ACT_INSERT, rows_q[i], cols_q[i], rnd64(), i, $urandom_range(0, 8191));
		end
		cnt = ($urandom_range(0, 99) < 85) ? n_entries : $urandom_range(0, n_entries);
		if ($urandom_range(0, 19) == 0)
			cnt = pick_count();
		send_item(ACT_FINALIZE, $urandom_range(0, 1023), $urandom_range(0, 1023), rnd64(),
			$urandom_range(0, 4095), cnt);
		for (int j = 0; j < n_lookups; j++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, n_entries - 1);
			if (r < 70)
				send_item(ACT_LOOKUP, rows_q[k], cols_q[k], rnd64(), $urandom_range(0, 4095),
					$urandom_range(0, 8191));
			else if (r < 90)
				send_item(ACT_LOOKUP, $urandom_range(0, rows_cfg - 1), $urandom_range(0, 1023),
					rnd64(), $urandom_range(0, 4095), $urandom_range(0, 8191));
			else
				send_item(ACT_LOOKUP, $urandom_range(0, 1023), $urandom_range(0, 1023),
					rnd64(), $urandom_range(0, 4095), $urandom_range(0, 8191));
		end
	endtask

	task automatic test_row_builds();
		int src_p [4];
		int snk_p [4];
		src_p = '{0, 66, 0, 8};
		snk_p = '{0, 0, 66, 8};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct  = src_p[p];
			snk_stall_pct = snk_p[p];
			for (int b = 0; b < 6; b++) begin
				set_rows(pick_rows());
				build_and_probe($urandom_range(1, 30), $urandom_range(5, 15));
			end
		end
	endtask

	task automatic test_mixed_noise();
		act_t act;
		int   row;
		int   src_p [4];
		int   snk_p [4];
		src_p = '{8, 0, 66, 0};
		snk_p = '{8, 66, 0, 0};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct  = src_p[p];
			snk_stall_pct = snk_p[p];
			set_rows(pick_rows());
			for (int n = 0; n < 135; n++) begin
				act = act_t'($urandom_range(0, 3));
				if (act == ACT_CLEAR && $urandom_range(0, 3) != 0)
					act = ACT_LOOKUP;
				row = ($urandom_range(0, 1) == 0) ? $urandom_range(0, rows_cfg - 1) :
					$urandom_range(0, 1023);
				send_item(act, row, $urandom_range(0, 1023), rnd64(),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) :
					$urandom_range(0, 4095), pick_count());
			end
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		set_rows($urandom_range(4, 32));
		hold_len = 300;
		for (int n = 0; n < 30; n++)
			send_item(($urandom_range(0, 1) == 0) ? ACT_INSERT : ACT_LOOKUP,
				$urandom_range(0, rows_cfg - 1), $urandom_range(0, 15), rnd64(),
				$urandom_range(0, 63), $urandom_range(0, 8191));
		wait_idle();
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				m_tready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else begin
				m_tready = ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				$error("result with no pending transaction: read_value=%h found=%b status=%b",
					m_tdata, m_tuser[0], m_tuser[1]);
				failures++;
			end else begin
				due_ans = answers_due.pop_front();
				if (m_tdata !== due_ans.value) begin
					$error("read_value: expected %h, got %h", due_ans.value, m_tdata);
					failures++;
				end
				if (m_tuser[0] !== due_ans.found) begin
					$error("found: expected %b, got %b", due_ans.found, m_tuser[0]);
					failures++;
				end
				if (m_tuser[1] !== due_ans.status) begin
					$error("status: expected %b, got %b", due_ans.status, m_tuser[1]);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = ACT_INSERT;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		failures      = 0;
		quiet_cycles  = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_len      = 0;
		rows_cfg      = ROWS_MAX;
		entry_sum     = 0;
		for (int i = 0; i <= ROWS_MAX; i++)
			offs[i] = 0;
		for (int i = 0; i < SLOTS_MAX; i++)
			written[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_edges();
		test_row_builds();
		test_mixed_noise();
		test_backpressure();

		wait_idle();
		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ csr_matrix_build_and_lookup.f @@
hw/rtl/csrmb_pkg.sv
hw/rtl/csrmb_ram.sv
hw/rtl/csrmb_ctrl.sv
hw/rtl/csrmb_dp.sv
hw/rtl/csr_matrix_build_and_lookup.sv
sim/csr_matrix_build_and_lookup_tb.sv
